// File: rtl/rdfe_pkg.sv
// rotary digit field editor: shared item types, codes and the power-of-ten table
`default_nettype none

package rdfe_pkg;

	localparam int VALUE_W  = 50;
	localparam int STEP_W   = 4;
	localparam int INDEX_W  = 3;
	localparam int KIND_W   = 2;
	localparam int POS_W    = 4;
	localparam int DCOUNT_W = 4;
	localparam int FCOUNT_W = 4;
	localparam int CFG_W    = 32;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_EVENT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	// configuration register indexes
	localparam logic REG_FIELD_COUNT  = 1'b0;
	localparam logic REG_DIGIT_COUNTS = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [STEP_W-1:0]  step;
		logic [INDEX_W-1:0]        field_index;
		logic [VALUE_W-1:0]        new_value;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] selected_field;
		logic               editing;
		logic               digit_mode;
		logic [POS_W-1:0]   edit_position;
		logic [VALUE_W-1:0] field_value;
	} out_item_t;

	// 10^e for e in 0..15
	function automatic logic [VALUE_W-1:0] pow10(input logic [DCOUNT_W-1:0] e);
		logic [VALUE_W-1:0] r;
		case (e)
			4'd0:    r = 50'd1;
			4'd1:    r = 50'd10;
			4'd2:    r = 50'd100;
			4'd3:    r = 50'd1000;
			4'd4:    r = 50'd10000;
			4'd5:    r = 50'd100000;
			4'd6:    r = 50'd1000000;
			4'd7:    r = 50'd10000000;
			4'd8:    r = 50'd100000000;
			4'd9:    r = 50'd1000000000;
			4'd10:   r = 50'd10000000000;
			4'd11:   r = 50'd100000000000;
			4'd12:   r = 50'd1000000000000;
			4'd13:   r = 50'd10000000000000;
			4'd14:   r = 50'd100000000000000;
			default: r = 50'd1000000000000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/rotary_digit_field_editor.sv
// rotary digit field editor: top level with input stage, field state and result register
`default_nettype none

// Keeps up to MAX_FIELDS decimal fields edited from a rotary encoder. Each
// item (encoder step or press, field write, field read) is captured in an
// input register, processed by one pass of logic (a power-of-ten lookup, a
// 50 by 4 bit multiply-add and a clamp to 0..10^digits-1) and lands in the
// result register together with the state update; one item is taken every
// cycle as long as results are taken. Every item gives exactly one result,
// reflecting the state after that item. Configuration writes (field count,
// packed digit counts) take effect at once and are meant for times when no
// item is in flight.
module rotary_digit_field_editor #(
	parameter int MAX_FIELDS = 8,
	parameter int MAX_DIGITS = 15
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire                       cfg_index,
	input  wire [rdfe_pkg::CFG_W-1:0] cfg_data,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  rdfe_pkg::in_item_t        in_item,
	output logic                      out_valid,
	input  wire                       out_ready,
	output rdfe_pkg::out_item_t       out_item
);
	import rdfe_pkg::*;

	// selection width and a field index width that holds both forms
	localparam int SEL_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam int IDX_W = (SEL_W > INDEX_W) ? SEL_W : INDEX_W;
	localparam int SUM_W = VALUE_W + 6;

	// configuration registers
	logic [FCOUNT_W-1:0] field_count_q;
	logic [CFG_W-1:0]    digit_counts_q;

	// field state
	logic [VALUE_W-1:0] vals_q [MAX_FIELDS];
	logic [POS_W-1:0]   pos_q  [MAX_FIELDS];
	logic               mode_q [MAX_FIELDS];
	logic [SEL_W-1:0]   sel_q;
	logic               edit_q;

	// input stage
	logic     valid_s1;
	in_item_t item_s1;

	// result register
	logic      out_valid_q;
	out_item_t out_q;

	logic advance;

	// next state from the item in the input stage
	logic [VALUE_W-1:0] vals_d [MAX_FIELDS];
	logic [POS_W-1:0]   pos_d  [MAX_FIELDS];
	logic               mode_d [MAX_FIELDS];
	logic [SEL_W-1:0]   sel_d;
	logic               edit_d;
	out_item_t          res_d;

	// digit count of a field: fields past the eighth have none
	function automatic logic [DCOUNT_W-1:0] digits_of(input logic [IDX_W-1:0] f,
		input logic [CFG_W-1:0] dc);
		logic [DCOUNT_W-1:0] d;
		d = DCOUNT_W'(dc >> {f, 2'b00});
		if (int'(d) > MAX_DIGITS) begin
			d = DCOUNT_W'(MAX_DIGITS);
		end
		return d;
	endfunction

	// item moves on when the result register is free or being emptied
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		logic [FCOUNT_W:0]         n_fields;
		logic signed [5:0]         s_new;
		logic signed [5:0]         n_last;
		logic signed [5:0]         p_new;
		logic [IDX_W-1:0]          sel_x;
		logic [IDX_W-1:0]          idx_x;
		logic [DCOUNT_W-1:0]       dig;
		logic [DCOUNT_W-1:0]       expo;
		logic [VALUE_W-1:0]        lim;
		logic signed [SUM_W-1:0]   prod;
		logic signed [SUM_W-1:0]   sum;
		logic [POS_W-1:0]          pos_cur;

		vals_d = vals_q;
		pos_d  = pos_q;
		mode_d = mode_q;
		sel_d  = sel_q;
		edit_d = edit_q;

		// fields in use, zero taken as one, capped at the storage size
		if (field_count_q == '0) begin
			n_fields = (FCOUNT_W+1)'(1);
		end else if (int'(field_count_q) > MAX_FIELDS) begin
			n_fields = (FCOUNT_W+1)'(MAX_FIELDS);
		end else begin
			n_fields = {1'b0, field_count_q};
		end
		n_last = $signed(6'(n_fields)) - 6'sd1;
		s_new  = $signed(6'(sel_q)) + 6'(item_s1.step);

		sel_x   = IDX_W'(sel_q);
		idx_x   = IDX_W'(item_s1.field_index);
		pos_cur = pos_q[sel_q];
		dig     = digits_of(sel_x, digit_counts_q);
		p_new   = $signed(6'(pos_cur)) + 6'(item_s1.step);

		// value step: weight of the digit under the edit position
		expo = (pos_cur > dig) ? '0 : DCOUNT_W'(dig - pos_cur);
		lim  = pow10(dig) - VALUE_W'(1);
		prod = $signed({6'd0, pow10(expo)}) * SUM_W'(item_s1.step);
		sum  = $signed({6'd0, vals_q[sel_q]}) + prod;

		case (item_s1.kind)
			KIND_EVENT: begin
				if (edit_q) begin
					if (item_s1.step == '0) begin
						// press toggles mode, or leaves editing from the exit slot
						if (pos_cur != '0) begin
							mode_d[sel_q] = !mode_q[sel_q];
						end else begin
							edit_d = 1'b0;
						end
					end else if (mode_q[sel_q]) begin
						// digit select: move position, clamped to 0..digits
						if (p_new < 0) begin
							pos_d[sel_q] = '0;
						end else if (p_new > $signed(6'(dig))) begin
							pos_d[sel_q] = POS_W'(dig);
						end else begin
							pos_d[sel_q] = POS_W'(p_new);
						end
					end else if (pos_cur != '0) begin
						// value change, saturated to 0..limit
						if (sum < 0) begin
							vals_d[sel_q] = '0;
						end else if (sum > $signed({6'd0, lim})) begin
							vals_d[sel_q] = lim;
						end else begin
							vals_d[sel_q] = sum[VALUE_W-1:0];
						end
					end
				end else begin
					// move selection with wrap at both ends; a press starts editing
					if (s_new < 0) begin
						sel_d = SEL_W'(n_last);
					end else if (s_new > n_last) begin
						sel_d = '0;
					end else begin
						sel_d = SEL_W'(s_new);
					end
					if (item_s1.step == '0) begin
						edit_d = 1'b1;
					end
				end
			end
			KIND_WRITE: begin
				// writes beyond the stored fields are dropped
				if (int'(idx_x) < MAX_FIELDS) begin
					lim = pow10(digits_of(idx_x, digit_counts_q)) - VALUE_W'(1);
					vals_d[idx_x[SEL_W-1:0]] = (item_s1.new_value > lim) ? lim :
						item_s1.new_value;
				end
			end
			default: begin
				// read and unknown kinds leave the state alone
			end
		endcase

		// result reflects the state after this item
		res_d.selected_field = INDEX_W'(IDX_W'(sel_d));
		res_d.editing        = edit_d;
		res_d.digit_mode     = mode_d[sel_d];
		res_d.edit_position  = pos_d[sel_d];
		res_d.field_value    = (int'(idx_x) < MAX_FIELDS) ? vals_d[idx_x[SEL_W-1:0]] : '0;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_count_q  <= FCOUNT_W'(1);
			digit_counts_q <= 32'h4444_4444;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIELD_COUNT:  field_count_q  <= cfg_data[FCOUNT_W-1:0];
				REG_DIGIT_COUNTS: digit_counts_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// field state, updated as the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FIELDS; i++) begin
				vals_q[i] <= '0;
				pos_q[i]  <= '0;
				mode_q[i] <= 1'b1;
			end
			sel_q  <= '0;
			edit_q <= 1'b0;
		end else if (advance) begin
			vals_q <= vals_d;
			pos_q  <= pos_d;
			mode_q <= mode_d;
			sel_q  <= sel_d;
			edit_q <= edit_d;
		end
	end

	// input stage and result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			out_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// testbench for the rotary digit field editor: random and directed items against a predictor
`timescale 1ns / 100ps

module testbench;
	import rdfe_pkg::*;

	// kind 3 is not decoded by the block and behaves as a plain read
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	localparam int FIELDS       = 8;
	localparam int STALL_LIMIT  = 3000;	// cycles with no item moving on either side
	localparam int CHOKE_AT     = 500;	// results seen before the long receiver hold-off
	localparam int CHOKE_CYCLES = 250;
	localparam int PHASE_ITEMS  = 200;
	localparam int PHASES       = 7;
	localparam int SHOWN        = 10;	// mismatches printed in full

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic             cfg_index = REG_FIELD_COUNT;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_item_t         in_item   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_item;

	rotary_digit_field_editor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// predictor copy of the editor state and its two registers
	logic [VALUE_W-1:0]  model_value [FIELDS];
	logic [POS_W-1:0]    model_pos [FIELDS];
	logic                model_digit_mode [FIELDS];
	logic [INDEX_W-1:0]  model_sel;
	logic                model_editing;
	logic [FCOUNT_W-1:0] model_count;
	logic [CFG_W-1:0]    model_digits;

	in_item_t  queued_items [$];	// items waiting for the driver
	out_item_t predicted_views [$];	// editor views expected from the block, oldest first

	logic item_taken = 1'b0;	// the item on the bus went in at the last rising edge
	logic steady     = 1'b0;	// both sides run without idling
	logic choked     = 1'b0;
	int   choke_left   = 0;
	int   quiet_cycles = 0;
	int   items_taken  = 0;
	int   results_seen = 0;
	int   mismatches   = 0;
	int   value_steps  = 0;
	int   edit_entries = 0;
	int   settings     = 0;

	logic [FCOUNT_W-1:0] phase_count [PHASES] = '{4'd8, 4'd3, 4'd0, 4'd15, 4'd1, 4'd5, 4'd8};
	logic [CFG_W-1:0]    phase_digits [PHASES] = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
		32'h2F0F_5A31, 32'h0, 32'h9999_9999};

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor helpers

	function automatic longint ten_to(input int e);
		longint r;
		int     i;
		r = 1;
		for (i = 0; i < e; i++)
			r = r * 10;
		return r;
	endfunction

	// digit count of a field; a 4-bit count never exceeds the 15-digit cap
	function automatic int digits_of(input int f);
		return int'(model_digits[4*f +: 4]);
	endfunction

	// field count register with 0 read as 1 and anything above 8 read as 8
	function automatic int fields_in_use();
		int n;
		n = int'(model_count);
		if (n < 1)
			n = 1;
		if (n > FIELDS)
			n = FIELDS;
		return n;
	endfunction

	// applies one item to the predicted state and returns the view the block should report
	task automatic advance_editor(input in_item_t it, output out_item_t view);
		int     st;
		int     f;
		int     cur;
		int     d;
		int     n;
		int     s;
		int     p;
		int     e;
		longint v;
		longint lim;
		st  = int'($signed(it.step));
		f   = int'(it.field_index);
		cur = int'(model_sel);
		case (it.kind)
			KIND_EVENT: begin
				if (model_editing) begin
					d = digits_of(cur);
					if (st == 0) begin
						// press: toggle mode on a digit, leave editing on the exit slot
						if (model_pos[cur] != 0)
							model_digit_mode[cur] = ~model_digit_mode[cur];
						else
							model_editing = 1'b0;
					end else if (model_digit_mode[cur]) begin
						p = int'(model_pos[cur]) + st;
						if (p < 0)
							p = 0;
						if (p > d)
							p = d;
						model_pos[cur] = p[POS_W-1:0];
					end else if (model_pos[cur] != 0) begin
						// a position left above a shrunk digit count steps with weight one
						e   = (int'(model_pos[cur]) > d) ? 0 : d - int'(model_pos[cur]);
						lim = ten_to(d) - 1;
						v   = longint'(model_value[cur]) + ten_to(e) * st;
						if (v < 0)
							v = 0;
						if (v > lim)
							v = lim;
						model_value[cur] = v[VALUE_W-1:0];
						value_steps++;
					end
				end else begin
					// selection wraps at both ends, also from beyond a shrunk count
					n = fields_in_use();
					s = cur + st;
					if (s < 0)
						s = n - 1;
					if (s > n - 1)
						s = 0;
					model_sel = s[INDEX_W-1:0];
					if (st == 0) begin
						model_editing = 1'b1;
						edit_entries++;
					end
				end
			end
			KIND_WRITE: begin
				lim = ten_to(digits_of(f)) - 1;
				if (longint'(it.new_value) > lim)
					model_value[f] = lim[VALUE_W-1:0];
				else
					model_value[f] = it.new_value;
			end
			default: begin
				// reads and the spare kind leave everything alone
			end
		endcase
		view.selected_field = model_sel;
		view.editing        = model_editing;
		view.digit_mode     = model_digit_mode[model_sel];
		view.edit_position  = model_pos[model_sel];
		view.field_value    = model_value[f];
	endtask

	// ---------------------------------------------------------------- checking

	task automatic check_view(input out_item_t want, input out_item_t got);
		logic bad;
		bad = (got.selected_field !== want.selected_field) || (got.editing !== want.editing)
			|| (got.digit_mode !== want.digit_mode) || (got.edit_position !== want.edit_position)
			|| (got.field_value !== want.field_value);
		if (bad) begin
			mismatches++;
			if (mismatches <= SHOWN) begin
				$display("result %0d want: sel %0d ed %0b md %0b pos %0d val %0d",
					results_seen, want.selected_field, want.editing, want.digit_mode,
					want.edit_position, want.field_value);
				$display("           got: sel %0d ed %0b md %0b pos %0d val %0d",
					got.selected_field, got.editing, got.digit_mode, got.edit_position,
					got.field_value);
			end
		end
	endtask

	// predicts each accepted item and checks each accepted result at the rising edge
	always @(posedge clk) begin : scoreboard
		out_item_t want;
		if (in_valid && in_ready) begin
			advance_editor(in_item, want);
			predicted_views.push_back(want);
			items_taken++;
		end
		item_taken <= in_valid && in_ready;
		if (out_valid && out_ready) begin
			results_seen++;
			if (predicted_views.size() == 0) begin
				// result with nothing predicted
				mismatches++;
				if (mismatches <= SHOWN)
					$display("unexpected result %0d: sel %0d value %0d", results_seen,
						out_item.selected_field, out_item.field_value);
			end else begin
				check_view(predicted_views.pop_front(), out_item);
			end
		end
	end

	// watchdog: too long with nothing accepted on either side ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- driver and receiver

	// sender: holds an item until it is taken, otherwise idles now and then or offers the next
	always @(negedge clk) begin
		if (!arst_n || (in_valid && !item_taken)) begin
			// item still waiting, payload stays put
		end else if (queued_items.size() == 0 || (!steady && $urandom_range(99) < 18)) begin
			in_valid <= 1'b0;
		end else begin
			in_valid <= 1'b1;
			in_item  <= queued_items.pop_front();
		end
	end

	// receiver: random stalls, plus one long hold-off so the block backs up into its input
	always @(negedge clk) begin
		if (choke_left > 0) begin
			out_ready <= 1'b0;
			choke_left--;
		end else if (!choked && results_seen >= CHOKE_AT) begin
			out_ready  <= 1'b0;
			choke_left = CHOKE_CYCLES;
			choked     = 1'b1;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 18);
		end
	end

	// ---------------------------------------------------------------- stimulus helpers

	task automatic push_item(input logic [KIND_W-1:0] k, input int st, input int idx,
			input logic [VALUE_W-1:0] val);
		in_item_t it;
		it.kind        = k;
		it.step        = st[STEP_W-1:0];
		it.field_index = idx[INDEX_W-1:0];
		it.new_value   = val;
		queued_items.push_back(it);
	endtask

	// encoder event; the unused fields carry random bits
	task automatic spin(input int st);
		push_item(KIND_EVENT, st, $urandom_range(7), VALUE_W'({$urandom, $urandom}));
	endtask

	// leaves a step out now and then so some sessions come out broken
	task automatic maybe_spin(input int st);
		if ($urandom_range(99) >= 8)
			spin(st);
	endtask

	function automatic int random_turn();
		logic [STEP_W-1:0] s;
		do
			s = STEP_W'($urandom_range(15));
		while (s == 0);
		return int'($signed(s));
	endfunction

	// mix of full-width values, the exact limit, just under it and values inside the range
	function automatic logic [VALUE_W-1:0] random_value(input int idx);
		longint      lim;
		longint      v;
		logic [63:0] raw;
		lim = ten_to(digits_of(idx)) - 1;
		raw = {$urandom, $urandom};
		case ($urandom_range(3))
			0: v = longint'(raw[VALUE_W-1:0]);
			1: v = lim;
			2: begin
				v = lim - longint'($urandom_range(3));
				if (v < 0)
					v = 0;
			end
			default: v = longint'(raw[VALUE_W-1:0] % (lim + 1));
		endcase
		return v[VALUE_W-1:0];
	endfunction

	task automatic noise_item();
		int idx;
		idx = $urandom_range(7);
		push_item(KIND_W'($urandom_range(3)), int'($signed(4'($urandom_range(15)))), idx,
			random_value(idx));
	endtask

	// enter editing, pick a digit, turn the value, go back and leave
	task automatic edit_session();
		int k;
		if ($urandom_range(1))
			maybe_spin(random_turn());
		maybe_spin(0);
		k = $urandom_range(1, 3);
		repeat (k)
			maybe_spin($urandom_range(1, 4));
		maybe_spin(0);
		k = $urandom_range(2, 6);
		repeat (k) begin
			if ($urandom_range(7) == 0)
				noise_item();
			else
				maybe_spin(random_turn());
		end
		maybe_spin(0);
		maybe_spin(-8);
		maybe_spin(0);
	endtask

	// waits until every queued item is in and every result is out, then lets the pipe drain
	task automatic settle();
		while (queued_items.size() != 0 || in_valid || predicted_views.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FIELD_COUNT)
			model_count = data[FCOUNT_W-1:0];
		else
			model_digits = data;
	endtask

	task automatic configure(input logic [FCOUNT_W-1:0] count, input logic [CFG_W-1:0] digits);
		settle();
		write_reg(REG_FIELD_COUNT, CFG_W'(count));
		write_reg(REG_DIGIT_COUNTS, digits);
		settings++;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------- test sequence

	initial begin
		int i;
		int ph;
		int start;
		for (i = 0; i < FIELDS; i++) begin
			model_value[i]      = '0;
			model_pos[i]        = '0;
			model_digit_mode[i] = 1'b1;
		end
		model_sel     = '0;
		model_editing = 1'b0;
		model_count   = 4'd1;
		model_digits  = 32'h4444_4444;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one field, four digits each
		push_item(KIND_READ, 0, 0, '0);
		push_item(KIND_SPARE, 5, 3, '1);
		spin(7);	// a single field wraps onto itself both ways
		spin(-8);
		spin(0);	// start editing
		spin(7);	// position clamps at the digit count
		spin(0);	// value mode on the lowest digit
		spin(7);
		spin(-8);	// value floors at zero
		push_item(KIND_WRITE, 0, 0, '1);	// saturates to the four-digit limit
		push_item(KIND_WRITE, 0, 7, 50'd1234);	// write to a field not in use

		// field 0 drops to three digits while still editing on position four
		configure(4'd8, 32'h0F84_21F3);
		spin(5);	// digit weight of one, stored value above the new limit gets clamped
		spin(0);
		spin(-8);
		spin(0);	// exit slot leaves editing
		spin(-8);	// wrap below the first field
		spin(7);	// wrap past the last field
		push_item(KIND_WRITE, 0, 7, 50'd5);	// zero digits, limit zero
		push_item(KIND_WRITE, 0, 1, 50'd999999999999999);
		push_item(KIND_READ, 0, 1, '0);
		push_item(KIND_WRITE, 0, 1, '1);
		spin(6);	// select field 6, then shrink the count under it
		configure(4'd3, 32'h0F84_21F3);
		spin(1);	// out-of-range selection wraps to the first field

		// random phases, each under its own register setting
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 0 || ph == 3 || ph == 5)
				phase_digits[ph] = $urandom;
			configure(phase_count[ph], phase_digits[ph]);
			steady = (ph == 3);
			start  = queued_items.size();
			while (queued_items.size() - start < PHASE_ITEMS) begin
				if ($urandom_range(99) < 65)
					edit_session();
				else
					noise_item();
			end
		end
		settle();
		steady = 1'b0;
		repeat (8) @(posedge clk);

		$display("run covered %0d items, %0d register settings, %0d edit sessions, %0d value turns",
			items_taken, settings, edit_entries, value_steps);
		$display("%0d results checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && predicted_views.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/rdfe_pkg.sv
rtl/rotary_digit_field_editor.sv
sim/testbench.sv
